// ===== rtl/ptms_pkg.sv =====
// Package with shared constants, types and state codes of the pixel statistics block.
`timescale 1ns / 1ps
package ptms_pkg;
  localparam int MaxPixels = 4096;
  localparam int MaxFrames = 1024;
  localparam int SampleWidth = 16;
  localparam int PixW = $clog2(MaxPixels);
  localparam int SumW = 26;
  localparam int SqW = 42;
  localparam int NpW = 13;
  localparam int NtW = 11;

  localparam logic CFG_NUM_PIXELS = 1'b0;
  localparam logic CFG_NUM_FRAMES = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CALC, ST_DIV, ST_SQRT, ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic wr;
    logic calc;
    logic div_start;
    logic sqrt_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_frame;
    logic div_done;
    logic sqrt_done;
  } stat_t;
endpackage

// ===== rtl/ptms_ram.sv =====
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module ptms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ptms_ctrl.sv =====
// Controller state machine that sequences each sample beat through the datapath.
`timescale 1ns / 1ps
module ptms_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            out_busy,
  input  ptms_pkg::stat_t stat,
  output ptms_pkg::cmd_t  cmd
);
  ptms_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptms_pkg::ST_IDLE: if (in_valid && !cfg_valid) state_nxt = ptms_pkg::ST_READ;
      ptms_pkg::ST_READ: begin
        if (stat.last_frame) state_nxt = ptms_pkg::ST_CALC;
        else state_nxt = ptms_pkg::ST_IDLE;
      end
      ptms_pkg::ST_CALC: state_nxt = ptms_pkg::ST_DIV;
      ptms_pkg::ST_DIV: if (stat.div_done) state_nxt = ptms_pkg::ST_SQRT;
      ptms_pkg::ST_SQRT: if (stat.sqrt_done) state_nxt = ptms_pkg::ST_OUT;
      ptms_pkg::ST_OUT: if (!out_busy) state_nxt = ptms_pkg::ST_IDLE;
      default: state_nxt = ptms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      ptms_pkg::ST_IDLE: begin
        in_ready = !cfg_valid;
        cfg_ready = 1'b1;
        cmd.capture = in_valid && !cfg_valid;
      end
      ptms_pkg::ST_READ: cmd.wr = 1'b1;
      ptms_pkg::ST_CALC: begin
        cmd.calc = 1'b1;
        cmd.div_start = 1'b1;
      end
      ptms_pkg::ST_DIV: cmd.sqrt_start = stat.div_done;
      ptms_pkg::ST_SQRT: ;
      ptms_pkg::ST_OUT: cmd.out_load = !out_busy;
      default: ;
    endcase
  end
endmodule

// ===== rtl/ptms_dp.sv =====
// Datapath with accumulator stores, counters, divider, square root and output register.
`timescale 1ns / 1ps
module ptms_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ptms_pkg::cmd_t                     cmd,
  output ptms_pkg::stat_t                    stat,
  input  logic signed [ptms_pkg::SampleWidth-1:0] in_sample,
  input  logic                               cfg_valid,
  input  logic                               cfg_index,
  input  logic                               cfg_hit,
  input  logic [31:0]                        cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_busy,
  output logic [11:0]                        out_pixel_index,
  output logic signed [23:0]                 out_mean_q8,
  output logic [23:0]                        out_stddev_q8,
  output logic                               out_single_frame
);
  localparam int PW = ptms_pkg::PixW;
  localparam int SW = ptms_pkg::SumW;
  localparam int QW = ptms_pkg::SqW;

  logic [ptms_pkg::NpW-1:0] np_r;
  logic [ptms_pkg::NtW-1:0] nt_r;
  logic [PW-1:0] pix_r;
  logic [9:0] frm_r;
  logic signed [ptms_pkg::SampleWidth-1:0] smp_r;
  logic [PW-1:0] np_eff, nt_m1;
  logic [ptms_pkg::NtW-1:0] nt_eff;
  logic first_frame;

  always_comb begin
    if (np_r == '0) np_eff = PW'(0);
    else if (np_r > ptms_pkg::NpW'(ptms_pkg::MaxPixels)) np_eff = PW'(ptms_pkg::MaxPixels - 1);
    else np_eff = PW'(np_r - 1'b1);
    if (nt_r == '0) nt_eff = ptms_pkg::NtW'(1);
    else if (nt_r > ptms_pkg::NtW'(ptms_pkg::MaxFrames)) nt_eff = ptms_pkg::NtW'(ptms_pkg::MaxFrames);
    else nt_eff = nt_r;
  end
  assign nt_m1 = PW'(nt_eff - 1'b1);
  assign first_frame = (frm_r == '0);
  assign stat.last_frame = ({2'b0, frm_r} == nt_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_r <= ptms_pkg::NpW'(ptms_pkg::MaxPixels);
      nt_r <= ptms_pkg::NtW'(16);
      pix_r <= '0;
      frm_r <= '0;
    end else if (cfg_valid && cfg_hit) begin
      if (cfg_index == ptms_pkg::CFG_NUM_PIXELS) np_r <= cfg_data[ptms_pkg::NpW-1:0];
      else np_r <= np_r;
      if (cfg_index == ptms_pkg::CFG_NUM_FRAMES) nt_r <= cfg_data[ptms_pkg::NtW-1:0];
      pix_r <= '0;
      frm_r <= '0;
    end else if (cmd.wr) begin
      if (pix_r == np_eff) begin
        pix_r <= '0;
        frm_r <= stat.last_frame ? '0 : frm_r + 1'b1;
      end else begin
        pix_r <= pix_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) smp_r <= in_sample;
  end

  logic signed [SW-1:0] sum_rd, sum_new;
  logic [QW-1:0] sq_rd, sq_new;
  logic signed [31:0] smp_x;
  logic [31:0] sq_smp;
  assign smp_x = 32'(smp_r);
  assign sq_smp = 32'(smp_x * smp_x);
  assign sum_new = (first_frame ? SW'(0) : sum_rd) + SW'(smp_r);
  assign sq_new = (first_frame ? QW'(0) : sq_rd) + QW'(sq_smp);

  ptms_ram #(.Width(SW), .Depth(ptms_pkg::MaxPixels)) u_sum (
    .clk(clk), .we(cmd.wr), .waddr(pix_r), .wdata(sum_new), .raddr(pix_r), .rdata(sum_rd));
  ptms_ram #(.Width(QW), .Depth(ptms_pkg::MaxPixels)) u_sq (
    .clk(clk), .we(cmd.wr), .waddr(pix_r), .wdata(sq_new), .raddr(pix_r), .rdata(sq_rd));

  logic signed [SW-1:0] sumv_r;
  logic [QW-1:0] sqv_r;
  logic [PW-1:0] pixv_r;
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      sumv_r <= sum_new;
      sqv_r <= sq_new;
      pixv_r <= pix_r;
    end
  end

  // Long division units: mean and variance share the same restoring divider sequence.
  logic [SW-1:0] asum;
  logic [52:0] va_r, vb_r;
  logic [19:0] d_r;
  logic [1:0] ph_r;
  logic [6:0] cnt_r;
  logic [68:0] num_r;
  logic [47:0] quo_r;
  logic [19:0] rem_r;
  logic [20:0] rem_sh;
  logic neg_r, div_busy_r;
  logic [33:0] mnum_r;
  logic [33:0] mquo_r;
  logic [10:0] mrem_r;
  logic [11:0] mrem_sh;
  assign asum = sumv_r[SW-1] ? SW'(-sumv_r) : SW'(sumv_r);
  assign rem_sh = {rem_r, num_r[68]};
  assign mrem_sh = {mrem_r, mnum_r[33]};

  // Multiply phases: phase 0 forms nt*sumsq and sum^2, phase 1 subtracts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      ph_r <= '0;
    end else if (cmd.calc) begin
      va_r <= 53'(nt_eff) * 53'(sqv_r);
      vb_r <= 53'(asum) * 53'(asum);
      d_r <= 20'(nt_eff) * 20'(nt_m1);
      neg_r <= sumv_r[SW-1];
      mnum_r <= {asum, 8'b0};
      ph_r <= 2'd1;
      div_busy_r <= 1'b0;
    end else if (ph_r == 2'd1) begin
      num_r <= (va_r > vb_r) ? {va_r - vb_r, 16'b0} : 69'b0;
      rem_r <= '0;
      quo_r <= '0;
      mrem_r <= '0;
      mquo_r <= '0;
      cnt_r <= 7'd69;
      ph_r <= 2'd2;
      div_busy_r <= 1'b1;
    end else if (div_busy_r) begin
      if (cnt_r == '0) begin
        div_busy_r <= 1'b0;
        ph_r <= '0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
        num_r <= {num_r[67:0], 1'b0};
        if (rem_sh >= {1'b0, d_r}) begin
          rem_r <= 20'(rem_sh - {1'b0, d_r});
          quo_r <= {quo_r[46:0], 1'b1};
        end else begin
          rem_r <= rem_sh[19:0];
          quo_r <= {quo_r[46:0], 1'b0};
        end
        if (cnt_r <= 7'd34) begin
          mnum_r <= {mnum_r[32:0], 1'b0};
          if (mrem_sh >= {1'b0, nt_eff}) begin
            mrem_r <= 11'(mrem_sh - {1'b0, nt_eff});
            mquo_r <= {mquo_r[32:0], 1'b1};
          end else begin
            mrem_r <= mrem_sh[10:0];
            mquo_r <= {mquo_r[32:0], 1'b0};
          end
        end
      end
    end
  end
  assign stat.div_done = div_busy_r && (cnt_r == '0);

  // The quotient is floor(65536*v/d); it stays below 2^47, so its root fits 24 bits.
  logic [63:0] sx_r, sres_r, sbit_r;
  logic sq_busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sx_r <= 64'(quo_r);
      sres_r <= '0;
      sbit_r <= 64'h4000_0000_0000_0000;
      sq_busy_r <= 1'b1;
    end else if (sq_busy_r) begin
      if (sbit_r == '0) begin
        sq_busy_r <= 1'b0;
      end else begin
        if (sx_r >= sres_r + sbit_r) begin
          sx_r <= sx_r - (sres_r + sbit_r);
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
    end
  end
  assign stat.sqrt_done = sq_busy_r && (sbit_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
      out_pixel_index <= 12'(pixv_r);
      out_mean_q8 <= neg_r ? 24'(-mquo_r) : 24'(mquo_r);
      out_single_frame <= (nt_eff == ptms_pkg::NtW'(1));
      if (nt_eff == ptms_pkg::NtW'(1)) out_stddev_q8 <= '0;
      else if (sres_r > 64'hFF_FFFF) out_stddev_q8 <= 24'hFF_FFFF;
      else out_stddev_q8 <= sres_r[23:0];
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
  assign out_busy = out_valid && !out_ready;
endmodule

// ===== rtl/pixel_time_mean_stddev.sv =====
// Top level of the per-pixel temporal mean and standard deviation block.
`timescale 1ns / 1ps
// Each accumulation beat does a store read, then a write back. A beat of the
// final frame also runs a 69-step long division and a 32-step square root; its result
// beat is loaded into the output register once the previous result beat has left it,
// and the next sample beat can be accepted in the same cycle as the result is offered.
// Configuration beats are accepted only while no sample is in flight.
module pixel_time_mean_stddev (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_pixel_index,
  output logic signed [23:0] out_mean_q8,
  output logic [23:0] out_stddev_q8,
  output logic        out_single_frame
);
  ptms_pkg::cmd_t cmd;
  ptms_pkg::stat_t stat;
  logic out_busy;

  ptms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .out_busy(out_busy), .stat(stat), .cmd(cmd));

  ptms_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_sample(in_sample),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index[0]), .cfg_hit(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_busy(out_busy),
    .out_pixel_index(out_pixel_index), .out_mean_q8(out_mean_q8),
    .out_stddev_q8(out_stddev_q8), .out_single_frame(out_single_frame));
endmodule

// ===== sim/tb_pixel_time_mean_stddev.sv =====
// Self-checking testbench for the per-pixel temporal mean and standard deviation block.
`timescale 1ns / 1ps
module tb_pixel_time_mean_stddev;
  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_sample;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [0:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               out_valid;
  logic               out_ready;
  logic [11:0]        out_pixel_index;
  logic signed [23:0] out_mean_q8;
  logic [23:0]        out_stddev_q8;
  logic               out_single_frame;

  pixel_time_mean_stddev u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_index(out_pixel_index),
    .out_mean_q8(out_mean_q8), .out_stddev_q8(out_stddev_q8),
    .out_single_frame(out_single_frame)
  );

  typedef struct {
    logic [11:0] pixel;
    logic [23:0] mean;
    logic [23:0] stddev;
    logic        single;
  } pixel_stats_t;

  typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [0:0]   index;
    logic [31:0]  data;
    logic [15:0]  smp;
    bit           fixed;
    pixel_stats_t stats;
  } row_t;

  pixel_stats_t stats_queue[$];
  int errors = 0;
  int in_idle = 0;
  int out_idle = 0;

  longint          sum_store[ptms_pkg::MaxPixels];
  longint unsigned sq_store[ptms_pkg::MaxPixels];
  int pix_cnt, frm_cnt, np_reg, nt_reg;

  logic         beat_seen;
  pixel_stats_t beat_stats;

  function automatic int eff_pixels();
    if (np_reg == 0) return 1;
    if (np_reg > ptms_pkg::MaxPixels) return ptms_pkg::MaxPixels;
    return np_reg;
  endfunction

  function automatic int eff_frames();
    if (nt_reg == 0) return 1;
    if (nt_reg > ptms_pkg::MaxFrames) return ptms_pkg::MaxFrames;
    return nt_reg;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic bit accumulate_pixel(logic signed [15:0] smp, output pixel_stats_t st);
    int np, nt, px;
    longint s, sum, mean;
    longint unsigned mag, asum, a, b, v, d, q, r, dev;
    bit produced = 0;
    np = eff_pixels();
    nt = eff_frames();
    px = pix_cnt;
    s = smp;
    mag = (s < 0) ? -s : s;
    if (frm_cnt == 0) begin
      sum_store[px] = s;
      sq_store[px] = mag * mag;
    end else begin
      sum_store[px] += s;
      sq_store[px] += mag * mag;
    end
    if (frm_cnt + 1 >= nt) begin
      sum = sum_store[px];
      mean = (sum * 256) / nt;
      dev = 0;
      st.single = (nt == 1);
      if (nt != 1) begin
        asum = (sum < 0) ? -sum : sum;
        a = nt * sq_store[px];
        b = asum * asum;
        v = (a > b) ? a - b : 0;
        d = nt * (nt - 1);
        q = v / d;
        r = v % d;
        dev = int_sqrt((q << 16) + ((r << 16) / d));
        if (dev > 64'hFFFFFF) dev = 64'hFFFFFF;
      end
      st.pixel = px[11:0];
      st.mean = mean[23:0];
      st.stddev = dev[23:0];
      produced = 1;
    end
    pix_cnt++;
    if (pix_cnt >= np) begin
      pix_cnt = 0;
      frm_cnt++;
      if (frm_cnt >= nt) frm_cnt = 0;
    end
    return produced;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_sample(logic signed [15:0] smp, bit fixed, pixel_stats_t typed);
    logic rdy;
    pixel_stats_t st;
    if (in_idle > 0 && $urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    if (accumulate_pixel(smp, st)) begin
      if (fixed) stats_queue.push_back(typed);
      else stats_queue.push_back(st);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (stats_queue.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [31:0] data);
    logic rdy;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    if (idx == ptms_pkg::CFG_NUM_PIXELS) np_reg = data[12:0];
    else nt_reg = data[10:0];
    pix_cnt = 0;
    frm_cnt = 0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  always @(negedge clk) begin
    beat_seen = rst_n && out_valid && out_ready;
    beat_stats.pixel = out_pixel_index;
    beat_stats.mean = out_mean_q8;
    beat_stats.stddev = out_stddev_q8;
    beat_stats.single = out_single_frame;
  end

  always @(posedge clk) begin
    out_ready <= (out_idle == 0) || ($urandom_range(99) >= out_idle);
    if (beat_seen) begin
      if (stats_queue.size() == 0) begin
        report_mismatch("unexpected beat pixel", beat_stats.pixel, 0);
      end else begin
        pixel_stats_t want;
        want = stats_queue.pop_front();
        if (beat_stats.pixel !== want.pixel)
          report_mismatch("pixel_index", beat_stats.pixel, want.pixel);
        if (beat_stats.mean !== want.mean)
          report_mismatch("mean_q8", beat_stats.mean, want.mean);
        if (beat_stats.stddev !== want.stddev)
          report_mismatch("stddev_q8", beat_stats.stddev, want.stddev);
        if (beat_stats.single !== want.single)
          report_mismatch("single_frame", beat_stats.single, want.single);
      end
    end
  end

  row_t rows[] = '{
    '{ROW_CFG, ptms_pkg::CFG_NUM_PIXELS, 32'd2, 16'h0, 0, '{0, 0, 0, 0}},
    '{ROW_CFG, ptms_pkg::CFG_NUM_FRAMES, 32'd1, 16'h0, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'h7FFF, 1, '{12'd0, 24'h7FFF00, 24'd0, 1'b1}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'h8000, 1, '{12'd1, 24'h800000, 24'd0, 1'b1}},
    '{ROW_CFG, ptms_pkg::CFG_NUM_FRAMES, 32'd0, 16'h0, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'h0000, 1, '{12'd0, 24'd0, 24'd0, 1'b1}},
    '{ROW_CFG, ptms_pkg::CFG_NUM_PIXELS, 32'd0, 16'h0, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'h0001, 1, '{12'd0, 24'd256, 24'd0, 1'b1}},
    '{ROW_CFG, ptms_pkg::CFG_NUM_PIXELS, 32'hFFFFFFFF, 16'h0, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'hFFFF, 1, '{12'd0, 24'hFFFF00, 24'd0, 1'b1}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'h0005, 1, '{12'd1, 24'd1280, 24'd0, 1'b1}},
    '{ROW_CFG, ptms_pkg::CFG_NUM_PIXELS, 32'd1, 16'h0, 0, '{0, 0, 0, 0}},
    '{ROW_CFG, ptms_pkg::CFG_NUM_FRAMES, 32'd2, 16'h0, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'h7FFF, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'h8000, 0, '{0, 0, 0, 0}},
    '{ROW_CFG, ptms_pkg::CFG_NUM_FRAMES, 32'hFFFFF7FF, 16'h0, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'h1234, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'hEDCB, 0, '{0, 0, 0, 0}},
    '{ROW_CFG, ptms_pkg::CFG_NUM_FRAMES, 32'd3, 16'h0, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'h0007, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'hFFFD, 0, '{0, 0, 0, 0}},
    '{ROW_SAMPLE, 1'b0, 32'd0, 16'h0064, 0, '{0, 0, 0, 0}}
  };

  initial begin
    int sent;
    int np_val, nt_val, count;
    logic [31:0] upper;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_ready = 1'b0;
    np_reg = ptms_pkg::MaxPixels;
    nt_reg = 16;
    pix_cnt = 0;
    frm_cnt = 0;
    foreach (sum_store[i]) begin
      sum_store[i] = 0;
      sq_store[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_register(rows[i].index, rows[i].data);
      else send_sample(rows[i].smp, rows[i].fixed, rows[i].stats);
    end

    sent = 0;
    while (sent < 400) begin
      if (sent < 133) begin
        in_idle = 22;
        out_idle = 61;
      end else if (sent < 266) begin
        in_idle = 61;
        out_idle = 22;
      end else begin
        in_idle = 0;
        out_idle = 0;
      end
      np_val = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      nt_val = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      upper = $urandom;
      if ($urandom_range(3) != 0 || sent == 0)
        write_register(ptms_pkg::CFG_NUM_PIXELS, (upper & ~32'h1FFF) | np_val);
      upper = $urandom;
      if ($urandom_range(3) != 0 || sent == 0)
        write_register(ptms_pkg::CFG_NUM_FRAMES, (upper & ~32'h7FF) | nt_val);
      count = eff_pixels() * eff_frames() * $urandom_range(1, 2);
      if ($urandom_range(6) == 0) count = $urandom_range(1, count);
      if (count > 400 - sent) count = 400 - sent;
      for (int k = 0; k < count; k++) send_sample(rand_sample(), 0, '{0, 0, 0, 0});
      sent += count;
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0 && stats_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
